// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, controller states and the command/status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int FIELD_W = 32;
    localparam int FUNC_W  = 3;

    localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CMP = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_GINIT,
        ST_GCD,
        ST_CHK,
        ST_WMAG,
        ST_SDEN,
        ST_WDEN,
        ST_FIN,
        ST_SFIN,
        ST_WFIN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_MAG,
        DIV_DEN,
        DIV_FIN
    } t_div_sel;

    typedef struct packed {
        logic     latch;
        logic     mul_cross;
        logic     mul_den;
        logic     prep;
        logic     gcd_init;
        logic     gcd_step;
        logic     g_save;
        logic     div_start;
        logic     div_wb;
        t_div_sel div_sel;
        logic     fin;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic need_div;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: unsigned restoring divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
    parameter int MW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_dividend,
    input  wire logic [MW-1:0] i_divisor,
    output logic               o_done,
    output logic [MW-1:0]      o_quo,
    output logic [MW-1:0]      o_rem
);

    localparam int CW = $clog2(MW + 1);
    localparam logic [CW-1:0] LAST = CW'(MW - 1);

    logic [MW-1:0] r_quo, n_quo;
    logic [MW-1:0] r_rem, n_rem;
    logic [MW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [MW:0]   shifted;
    logic [MW:0]   trial;

    always_comb begin
        shifted = {r_rem, r_quo[MW-1]};
        trial   = shifted - {1'b0, r_dvs};
        if (!trial[MW]) begin
            n_rem = trial[MW-1:0];
            n_quo = {r_quo[MW-2:0], 1'b1};
        end else begin
            n_rem = shifted[MW-1:0];
            n_quo = {r_quo[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== design/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Cross products, sign/magnitude forming, binary gcd, shared divider for
// reduction and for the whole/fraction split, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rau_pkg::t_cmd                 i_cmd,
    output rau_pkg::t_sts                      o_sts,
    input  wire logic [rau_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [WORD_BITS-1:0]          i_a_num,
    input  wire logic [WORD_BITS-1:0]          i_a_den,
    input  wire logic [WORD_BITS-1:0]          i_b_num,
    input  wire logic [WORD_BITS-1:0]          i_b_den,
    output logic signed [rau_pkg::FIELD_W-1:0] o_res_num,
    output logic [rau_pkg::FIELD_W-1:0]        o_res_den,
    output logic                               o_res_valid,
    output logic                               o_is_less,
    output logic                               o_is_equal,
    output logic                               o_is_greater,
    output logic signed [rau_pkg::FIELD_W-1:0] o_whole_part,
    output logic signed [rau_pkg::FIELD_W-1:0] o_frac_part
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * W;
    localparam int PW = 2 * W + 2;
    localparam int KW = $clog2(MW + 1);
    localparam int FW = rau_pkg::FIELD_W;

    localparam logic [MW-1:0] ONE  = {{(MW-1){1'b0}}, 1'b1};
    localparam logic [MW-1:0] HALF = ONE << (W - 1);
    localparam logic [MW-1:0] MAXN = HALF - ONE;
    localparam logic [MW-1:0] LIMP = HALF - (ONE << 1);

    // operand registers
    logic [rau_pkg::FUNC_W-1:0] r_func;
    logic signed [W-1:0] r_an, r_bn;
    logic [W-1:0]        r_ad, r_bd;

    // products
    logic signed [W:0]    m1a, m1b, m2a, m2b;
    logic signed [PW-1:0] prod1, prod2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic [MW-1:0]        r_p3;

    // sign/magnitude stage
    logic          r_neg, r_reduce, r_cmp;
    logic          r_lt, r_eq, r_gt;
    logic [MW-1:0] r_mag, r_den;
    logic          n_neg, n_reduce, n_cmp, n_lt, n_eq, n_gt;
    logic [MW-1:0] n_mag, n_den;

    logic                 s1, s2;
    logic signed [PW-1:0] abs1, abs2;
    logic [MW-1:0]        m1, m2;
    logic [W-1:0]         an_mag;

    // gcd
    logic [MW-1:0] r_gx, r_gy, r_g;
    logic [KW-1:0] r_k;
    logic [MW-1:0] g_val;

    // finish
    logic [W-1:0] r_nmag, r_dfin;
    logic         r_valid;
    logic         den_bad, num_ok;
    logic [MW-1:0] nmag_c;
    logic signed [W-1:0] num_w;
    logic signed [W-1:0] r_whole, r_frac;

    // divider
    logic [MW-1:0] div_dvd, div_dvs, div_quo, div_rem;
    logic          div_done;

    // output registers
    logic signed [W-1:0] r_o_num, r_o_whole, r_o_frac;
    logic [W-1:0]        r_o_den;
    logic                r_o_valid, r_o_lt, r_o_eq, r_o_gt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_an   <= i_a_num;
            r_ad   <= i_a_den;
            r_bn   <= i_b_num;
            r_bd   <= i_b_den;
        end
    end

    always_comb begin
        m2a = {1'b0, r_ad};
        if (i_cmd.mul_den) begin
            m1a = {1'b0, r_ad};
            m1b = {1'b0, r_bd};
            m2b = {r_bn[W-1], r_bn};
        end else if (r_func == rau_pkg::FN_MUL) begin
            m1a = {r_an[W-1], r_an};
            m1b = {r_bn[W-1], r_bn};
            m2b = {1'b0, r_bd};
        end else begin
            m1a = {r_an[W-1], r_an};
            m1b = {1'b0, r_bd};
            m2b = {r_bn[W-1], r_bn};
        end
        prod1 = PW'(m1a) * PW'(m1b);
        prod2 = PW'(m2a) * PW'(m2b);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_cross) begin
            r_p1 <= prod1;
            r_p2 <= prod2;
        end
        if (i_cmd.mul_den) begin
            r_p3 <= prod1[MW-1:0];
        end
    end

    always_comb begin
        s1   = r_p1[PW-1];
        s2   = r_p2[PW-1];
        abs1 = s1 ? -r_p1 : r_p1;
        abs2 = s2 ? -r_p2 : r_p2;
        m1   = abs1[MW-1:0];
        m2   = abs2[MW-1:0];
        // word-wide magnitude; the most negative value maps to 2^(W-1)
        an_mag = r_an[W-1] ? W'(-r_an) : W'(r_an);

        n_neg    = 1'b0;
        n_mag    = '0;
        n_den    = ONE;
        n_reduce = 1'b0;
        n_cmp    = 1'b0;
        n_lt     = 1'b0;
        n_eq     = 1'b0;
        n_gt     = 1'b0;

        case (r_func)
            rau_pkg::FN_ADD, rau_pkg::FN_SUB: begin
                // effective sign of the second term flips on subtract
                if (s1 == (s2 ^ (r_func == rau_pkg::FN_SUB))) begin
                    n_neg = s1;
                    n_mag = m1 + m2;
                end else if (m1 >= m2) begin
                    n_neg = s1;
                    n_mag = m1 - m2;
                end else begin
                    n_neg = ~s1;
                    n_mag = m2 - m1;
                end
                if (n_mag == '0) begin
                    n_neg = 1'b0;
                end
                n_den    = r_p3;
                n_reduce = 1'b1;
            end
            rau_pkg::FN_MUL: begin
                if (r_bn != '0) begin
                    n_neg    = s1;
                    n_mag    = m1;
                    n_den    = m2;
                    n_reduce = 1'b1;
                end
            end
            rau_pkg::FN_DIV: begin
                if (r_bn == '0) begin
                    // divide by zero: first operand passes unreduced
                    n_neg = r_an[W-1];
                    n_mag = MW'(an_mag);
                    n_den = MW'(r_ad);
                end else begin
                    n_neg    = (m1 != '0) && (s1 ^ s2);
                    n_mag    = m1;
                    n_den    = m2;
                    n_reduce = 1'b1;
                end
            end
            rau_pkg::FN_CMP: begin
                n_cmp = 1'b1;
                n_lt  = r_p1 < r_p2;
                n_eq  = r_p1 == r_p2;
                n_gt  = r_p1 > r_p2;
            end
            default: begin
                n_cmp = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            r_den    <= n_den;
            r_reduce <= n_reduce;
            r_cmp    <= n_cmp;
            r_lt     <= n_lt;
            r_eq     <= n_eq;
            r_gt     <= n_gt;
        end else if (i_cmd.div_wb && div_done) begin
            case (i_cmd.div_sel)
                rau_pkg::DIV_MAG: r_mag <= div_quo;
                rau_pkg::DIV_DEN: r_den <= div_quo;
                default: ;
            endcase
        end
    end

    // binary gcd: common factors of two counted in r_k
    assign g_val = (r_gx | r_gy) << r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_gx <= r_mag;
            r_gy <= r_den;
            r_k  <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_k  <= r_k + 1'b1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
        if (i_cmd.g_save) begin
            r_g <= g_val;
        end
    end

    always_comb begin
        den_bad = (r_den == '0) || (r_den > MAXN);
        if (r_neg) begin
            nmag_c = (r_mag > HALF) ? HALF : r_mag;
            num_ok = r_mag < MAXN;
        end else begin
            nmag_c = (r_mag > MAXN) ? MAXN : r_mag;
            num_ok = r_mag < LIMP;
        end
        num_w = r_neg ? -signed'(r_nmag) : signed'(r_nmag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_nmag  <= nmag_c[W-1:0];
            r_dfin  <= den_bad ? W'(1) : r_den[W-1:0];
            r_valid <= !r_cmp && !den_bad && num_ok;
        end
        if (i_cmd.div_wb && div_done && (i_cmd.div_sel == rau_pkg::DIV_FIN)) begin
            r_whole <= r_neg ? -signed'(div_quo[W-1:0]) : signed'(div_quo[W-1:0]);
            r_frac  <= r_neg ? -signed'(div_rem[W-1:0]) : signed'(div_rem[W-1:0]);
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            rau_pkg::DIV_MAG: begin
                div_dvd = r_mag;
                div_dvs = r_g;
            end
            rau_pkg::DIV_DEN: begin
                div_dvd = r_den;
                div_dvs = r_g;
            end
            default: begin
                div_dvd = MW'(r_nmag);
                div_dvs = MW'(r_dfin);
            end
        endcase
    end

    rau_div #(
        .MW(MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_num   <= num_w;
            r_o_den   <= r_dfin;
            r_o_valid <= r_valid;
            r_o_lt    <= r_lt;
            r_o_eq    <= r_eq;
            r_o_gt    <= r_gt;
            r_o_whole <= r_whole;
            r_o_frac  <= r_frac;
        end
    end

    assign o_sts.gcd_done = (r_gx == '0) || (r_gy == '0);
    assign o_sts.need_div = r_reduce && (r_g > ONE);
    assign o_sts.div_done = div_done;

    assign o_res_num    = FW'(r_o_num);
    assign o_res_den    = FW'(r_o_den);
    assign o_res_valid  = r_o_valid;
    assign o_is_less    = r_o_lt;
    assign o_is_equal   = r_o_eq;
    assign o_is_greater = r_o_gt;
    assign o_whole_part = FW'(r_o_whole);
    assign o_frac_part  = FW'(r_o_frac);

endmodule

`default_nettype wire

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// Steps the datapath through products, gcd, reduction and the final split,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output rau_pkg::t_cmd       o_cmd,
    input  wire rau_pkg::t_sts  i_sts
);

    rau_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = rau_pkg::DIV_MAG;

        unique case (r_state)
            rau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = rau_pkg::ST_MUL1;
                end
            end
            rau_pkg::ST_MUL1: begin
                o_cmd.mul_cross = 1'b1;
                n_state         = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                o_cmd.mul_den = 1'b1;
                n_state       = rau_pkg::ST_PREP;
            end
            rau_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = rau_pkg::ST_GINIT;
            end
            rau_pkg::ST_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = rau_pkg::ST_GCD;
            end
            rau_pkg::ST_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.g_save = 1'b1;
                    n_state      = rau_pkg::ST_CHK;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            rau_pkg::ST_CHK: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rau_pkg::DIV_MAG;
                    n_state         = rau_pkg::ST_WMAG;
                end else begin
                    n_state = rau_pkg::ST_FIN;
                end
            end
            rau_pkg::ST_WMAG: begin
                o_cmd.div_wb  = 1'b1;
                o_cmd.div_sel = rau_pkg::DIV_MAG;
                if (i_sts.div_done) begin
                    n_state = rau_pkg::ST_SDEN;
                end
            end
            rau_pkg::ST_SDEN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = rau_pkg::DIV_DEN;
                n_state         = rau_pkg::ST_WDEN;
            end
            rau_pkg::ST_WDEN: begin
                o_cmd.div_wb  = 1'b1;
                o_cmd.div_sel = rau_pkg::DIV_DEN;
                if (i_sts.div_done) begin
                    n_state = rau_pkg::ST_FIN;
                end
            end
            rau_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = rau_pkg::ST_SFIN;
            end
            rau_pkg::ST_SFIN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = rau_pkg::DIV_FIN;
                n_state         = rau_pkg::ST_WFIN;
            end
            rau_pkg::ST_WFIN: begin
                o_cmd.div_wb  = 1'b1;
                o_cmd.div_sel = rau_pkg::DIV_FIN;
                if (i_sts.div_done) begin
                    n_state = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != rau_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: fraction add/sub/mul/div/compare with gcd
// reduction, validity check and whole/fraction split.
// ----------------------------------------------------------------------------
// One beat is worked at a time. A beat first passes the setup steps (latch,
// cross products, denominator product, sign/magnitude, gcd init), then a
// binary gcd of one subtract or shift per cycle (ending at once when an
// operand is zero), then the shared restoring divider at one bit per cycle:
// two divisions when the result is reduced and the gcd exceeds one, and
// always one more for the whole/fraction split. A finished result waits in
// the output register while the next beat is already accepted.
`default_nettype none

module rational_arithmetic_unit_top #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rau_pkg::FUNC_W-1:0]    i_func,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_a_num,
    input  wire logic [rau_pkg::FIELD_W-1:0]   i_a_den,
    input  wire logic signed [rau_pkg::FIELD_W-1:0] i_b_num,
    input  wire logic [rau_pkg::FIELD_W-1:0]   i_b_den,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [rau_pkg::FIELD_W-1:0] o_res_num,
    output logic [rau_pkg::FIELD_W-1:0]        o_res_den,
    output logic                               o_res_valid,
    output logic                               o_is_less,
    output logic                               o_is_equal,
    output logic                               o_is_greater,
    output logic signed [rau_pkg::FIELD_W-1:0] o_whole_part,
    output logic signed [rau_pkg::FIELD_W-1:0] o_frac_part
);

    rau_pkg::t_cmd cmd;
    rau_pkg::t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rau_dp #(
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_a_num      (i_a_num[WORD_BITS-1:0]),
        .i_a_den      (i_a_den[WORD_BITS-1:0]),
        .i_b_num      (i_b_num[WORD_BITS-1:0]),
        .i_b_den      (i_b_den[WORD_BITS-1:0]),
        .o_res_num    (o_res_num),
        .o_res_den    (o_res_den),
        .o_res_valid  (o_res_valid),
        .o_is_less    (o_is_less),
        .o_is_equal   (o_is_equal),
        .o_is_greater (o_is_greater),
        .o_whole_part (o_whole_part),
        .o_frac_part  (o_frac_part)
    );

endmodule

`default_nettype wire
